// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the uri parser
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, disabled during reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== rtl/ipd_uri_pkg.sv =====
// types and constants for the +IPD request uri parser
// no dependencies; used by ipd_request_uri_parser_unit
package ipd_uri_pkg;

    localparam int URI_MAX = 64;
    localparam int CNT_W   = $clog2(URI_MAX + 1);
    localparam int LEN_W   = 7;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int TAG_LEN = 3;

    // element 0 is the first tag byte: 'I', 'P', 'D'
    typedef logic [TAG_LEN-1:0][7:0] tag_t;
    localparam tag_t TAG_EXPECT = {8'h44, 8'h50, 8'h49};

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_TAG     = 6'b000010,
        PH_SKIP_ID = 6'b000100,
        PH_SKIP_LN = 6'b001000,
        PH_METHOD  = 6'b010000,
        PH_URI     = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0]       uri_byte;
        logic             uri_end;
        logic [LEN_W-1:0] uri_length;
        logic             uri_truncated;
    } res_t;

endpackage

// ===== rtl/ipd_request_uri_parser_unit.sv =====
// +IPD notice parser: streams uri bytes and a closing length transaction
// depends on ipd_uri_pkg and assert_macros.svh
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid, in_ready, rx_byte                      | in
//  out     | out_valid, out_ready, uri_byte, uri_end,         | out
//          | uri_length, uri_truncated                        |
//
// one byte per cycle while in_ready is high: the parse state machine updates in the
// cycle a byte is taken and its result is registered into the output stage
// a two-entry output stage (register plus skid) keeps in_ready high for one
// stalled result; in_ready drops only while the skid entry is full
// asynchronous active-low reset returns to idle with empty tag and no results
module ipd_request_uri_parser_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   rx_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   uri_byte,
    output logic                         uri_end,
    output logic [ipd_uri_pkg::LEN_W-1:0] uri_length,
    output logic                         uri_truncated
);

    `include "assert_macros.svh"

    ipd_uri_pkg::phase_t                phase_reg, phase_next;
    logic [ipd_uri_pkg::CNT_W-1:0]      count_reg, count_next;
    ipd_uri_pkg::tag_t                  tag_reg, tag_next;
    logic                               ovf_reg, ovf_next;

    ipd_uri_pkg::res_t                  res_c;
    logic                               res_valid_c;
    logic                               accept;
    logic                               res_fire;

    ipd_uri_pkg::res_t                  out_reg;
    logic                               out_valid_reg;
    ipd_uri_pkg::res_t                  skid_reg;
    logic                               skid_valid_reg;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign res_fire = accept && res_valid_c;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        tag_next    = tag_reg;
        ovf_next    = ovf_reg;
        res_valid_c = 1'b0;
        res_c       = '0;
        if (accept)
        begin
            unique case (phase_reg)
                ipd_uri_pkg::PH_TAG:
                begin
                    if (rx_byte == ipd_uri_pkg::CH_COMMA ||
                        count_reg >= ipd_uri_pkg::CNT_W'(ipd_uri_pkg::TAG_LEN))
                    begin
                        count_next = '0;
                        phase_next = (tag_reg == ipd_uri_pkg::TAG_EXPECT) ?
                                     ipd_uri_pkg::PH_SKIP_ID : ipd_uri_pkg::PH_IDLE;
                    end
                    else
                    begin
                        tag_next[count_reg[1:0]] = rx_byte;
                        count_next = count_reg + ipd_uri_pkg::CNT_W'(1);
                    end
                end
                ipd_uri_pkg::PH_SKIP_ID:
                begin
                    if (rx_byte == ipd_uri_pkg::CH_COMMA)
                        phase_next = ipd_uri_pkg::PH_SKIP_LN;
                end
                ipd_uri_pkg::PH_SKIP_LN:
                begin
                    if (rx_byte == ipd_uri_pkg::CH_COLON)
                        phase_next = ipd_uri_pkg::PH_METHOD;
                end
                ipd_uri_pkg::PH_METHOD:
                begin
                    if (rx_byte == ipd_uri_pkg::CH_SLASH)
                        phase_next = ipd_uri_pkg::PH_URI;
                end
                ipd_uri_pkg::PH_URI:
                begin
                    if (rx_byte == ipd_uri_pkg::CH_SPACE)
                    begin
                        res_valid_c         = 1'b1;
                        res_c.uri_end       = 1'b1;
                        res_c.uri_length    = ipd_uri_pkg::LEN_W'(count_reg);
                        res_c.uri_truncated = ovf_reg;
                        phase_next          = ipd_uri_pkg::PH_IDLE;
                        count_next          = '0;
                        ovf_next            = 1'b0;
                    end
                    else if (count_reg < ipd_uri_pkg::CNT_W'(ipd_uri_pkg::URI_MAX))
                    begin
                        res_valid_c    = 1'b1;
                        res_c.uri_byte = rx_byte;
                        count_next     = count_reg + ipd_uri_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        // buffer full: drop the byte and flag the uri as truncated
                        ovf_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = ipd_uri_pkg::PH_IDLE;
                    if (rx_byte == ipd_uri_pkg::CH_PLUS)
                    begin
                        phase_next = ipd_uri_pkg::PH_TAG;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ipd_uri_pkg::PH_IDLE;
            count_reg <= '0;
            tag_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            tag_reg   <= tag_next;
            ovf_reg   <= ovf_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_ready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= res_fire;
                end
            end
            else if (res_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (res_fire)
                out_reg <= res_c;
        end
        else if (res_fire)
        begin
            skid_reg <= res_c;
        end
    end

    assign out_valid     = out_valid_reg;
    assign uri_byte      = out_reg.uri_byte;
    assign uri_end       = out_reg.uri_end;
    assign uri_length    = out_reg.uri_length;
    assign uri_truncated = out_reg.uri_truncated;

    `ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid entry held while output register empty")
    `ASSERT_NEXT(a_stall_to_skid, clk, rst_n,
        out_valid_reg && !out_ready && res_fire, skid_valid_reg && out_valid_reg,
        "result produced under stall was not kept")
    `ASSERT_IMPL(a_end_byte_zero, clk, rst_n, out_valid_reg && out_reg.uri_end,
        out_reg.uri_byte == 8'h00, "end transaction carries a nonzero byte")
    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= ipd_uri_pkg::CNT_W'(ipd_uri_pkg::URI_MAX),
        "uri count beyond capacity")

endmodule

// ===== test/ipd_request_uri_parser_unit_tb.sv =====
// self-checking bench for ipd_request_uri_parser_unit: directed notices, then a random byte stream
// expected uri transactions come from a cycle-free parser model kept inside the bench
// depends on ipd_uri_pkg and the rtl of ipd_request_uri_parser_unit
module ipd_request_uri_parser_unit_tb;

    localparam logic [23:0] TAG_IPD = "IPD";

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [7:0]          rx_byte = 8'h00;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [7:0]          uri_byte;
    logic                uri_end;
    logic [ipd_uri_pkg::LEN_W-1:0] uri_length;
    logic                uri_truncated;

    // parser model state
    ipd_uri_pkg::phase_t parse_ph;
    int unsigned         kept_cnt;
    logic [7:0]          tag_q [ipd_uri_pkg::TAG_LEN];
    logic                trunc_flag;

    ipd_uri_pkg::res_t   uri_expect_q [$];
    logic [7:0]          frame_q [$];
    bit                  no_idle = 1'b0;
    int                  fail_cnt = 0;
    int                  bytes_sent = 0;
    int                  notices_sent = 0;
    int                  uri_seen = 0;
    int                  ends_seen = 0;

    always #4 clk = ~clk;

    ipd_request_uri_parser_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .uri_byte      (uri_byte),
        .uri_end       (uri_end),
        .uri_length    (uri_length),
        .uri_truncated (uri_truncated)
    );

    // advance the parser model by one accepted byte, queue any uri transaction it yields
    function automatic void parse_byte(input logic [7:0] b);
        ipd_uri_pkg::res_t r;
        r = '0;
        case (parse_ph)
            ipd_uri_pkg::PH_TAG:
            begin
                // a comma or the fourth tag byte closes the tag; that byte is not stored
                if (b == ipd_uri_pkg::CH_COMMA || kept_cnt >= ipd_uri_pkg::TAG_LEN)
                begin
                    kept_cnt = 0;
                    parse_ph = ({tag_q[0], tag_q[1], tag_q[2]} == TAG_IPD) ?
                               ipd_uri_pkg::PH_SKIP_ID : ipd_uri_pkg::PH_IDLE;
                end
                else
                begin
                    tag_q[kept_cnt] = b;
                    kept_cnt++;
                end
            end
            ipd_uri_pkg::PH_SKIP_ID:
            begin
                if (b == ipd_uri_pkg::CH_COMMA)
                    parse_ph = ipd_uri_pkg::PH_SKIP_LN;
            end
            ipd_uri_pkg::PH_SKIP_LN:
            begin
                if (b == ipd_uri_pkg::CH_COLON)
                    parse_ph = ipd_uri_pkg::PH_METHOD;
            end
            ipd_uri_pkg::PH_METHOD:
            begin
                if (b == ipd_uri_pkg::CH_SLASH)
                    parse_ph = ipd_uri_pkg::PH_URI;
            end
            ipd_uri_pkg::PH_URI:
            begin
                if (b == ipd_uri_pkg::CH_SPACE)
                begin
                    r.uri_end       = 1'b1;
                    r.uri_length    = ipd_uri_pkg::LEN_W'(kept_cnt);
                    r.uri_truncated = trunc_flag;
                    uri_expect_q.push_back(r);
                    parse_ph   = ipd_uri_pkg::PH_IDLE;
                    kept_cnt   = 0;
                    trunc_flag = 1'b0;
                end
                else if (kept_cnt < ipd_uri_pkg::URI_MAX)
                begin
                    kept_cnt++;
                    r.uri_byte = b;
                    uri_expect_q.push_back(r);
                end
                else
                    trunc_flag = 1'b1;
            end
            default:
            begin
                if (b == ipd_uri_pkg::CH_PLUS)
                begin
                    parse_ph   = ipd_uri_pkg::PH_TAG;
                    kept_cnt   = 0;
                    trunc_flag = 1'b0;
                end
                else
                    parse_ph = ipd_uri_pkg::PH_IDLE;
            end
        endcase
    endfunction

    function automatic logic [7:0] other_byte(input logic [7:0] a, input logic [7:0] c);
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == a || v == c);
        return v;
    endfunction

    // one complete notice with random id, length, method and uri content, optionally with one tag byte corrupted
    function automatic void build_notice(input int uri_len, input bit bad_tag);
        logic [23:0] tag;
        int          k;
        tag = TAG_IPD;
        frame_q.delete();
        frame_q.push_back(ipd_uri_pkg::CH_PLUS);
        if (bad_tag)
        begin
            k = $urandom_range(0, 2);
            tag[8*k +: 8] = other_byte(tag[8*k +: 8], ipd_uri_pkg::CH_COMMA);
        end
        frame_q.push_back(tag[23:16]);
        frame_q.push_back(tag[15:8]);
        frame_q.push_back(tag[7:0]);
        // either a comma or any fourth byte closes the tag
        frame_q.push_back($urandom_range(0, 1) ? ipd_uri_pkg::CH_COMMA
                                               : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3))
            frame_q.push_back(other_byte(ipd_uri_pkg::CH_COMMA, ipd_uri_pkg::CH_COMMA));
        frame_q.push_back(ipd_uri_pkg::CH_COMMA);
        repeat ($urandom_range(0, 4))
            frame_q.push_back(other_byte(ipd_uri_pkg::CH_COLON, ipd_uri_pkg::CH_COLON));
        frame_q.push_back(ipd_uri_pkg::CH_COLON);
        repeat ($urandom_range(0, 5))
            frame_q.push_back(other_byte(ipd_uri_pkg::CH_SLASH, ipd_uri_pkg::CH_SLASH));
        frame_q.push_back(ipd_uri_pkg::CH_SLASH);
        repeat (uri_len)
            frame_q.push_back(other_byte(ipd_uri_pkg::CH_SPACE, ipd_uri_pkg::CH_SPACE));
        frame_q.push_back(ipd_uri_pkg::CH_SPACE);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        bit took;
        while (!no_idle && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        // in_ready only moves at the rising edge, so mid-cycle shows what the edge sees
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_frame(input int n);
        for (int i = 0; i < n; i++)
            send_byte(frame_q[i]);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (uri_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // right after reset the unwritten tag position is zero, so a two-byte tag fails
    task automatic test_short_tag();
        send_text("+IP,0,1:G /q ");
    endtask

    task automatic test_notice_extremes();
        send_text("+IPD,0,9:GET /");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ipd_uri_pkg::CH_SPACE);
    endtask

    // empty tag reuses the stored one, fourth byte closes the tag, then a tag mismatch
    task automatic test_tag_cases();
        send_text("+,,:/z ");
        send_text("+IPDX,:/ ");
        send_text("+IPE,1,2:P /n ");
    endtask

    task automatic test_stray_plus();
        send_text("+IPD,+,+:+/+ ");
    endtask

    task automatic test_uri_overflow();
        build_notice(ipd_uri_pkg::URI_MAX, 1'b0);
        send_frame(frame_q.size());
        build_notice(ipd_uri_pkg::URI_MAX + 5, 1'b0);
        send_frame(frame_q.size());
        wait_results_drained();
    endtask

    task automatic test_random_stream(input int n_bytes);
        int start;
        int pick;
        int ulen;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            no_idle = (bytes_sent - start > n_bytes / 3) && (bytes_sent - start < n_bytes / 2);
            pick = $urandom_range(0, 99);
            ulen = ($urandom_range(0, 19) == 0) ?
                   $urandom_range(ipd_uri_pkg::URI_MAX - 2, ipd_uri_pkg::URI_MAX + 6) :
                   $urandom_range(0, 12);
            if (pick < 85)
                build_notice(ulen, pick < 8);
            if (pick < 70)
            begin
                send_frame(frame_q.size());
                notices_sent++;
            end
            else if (pick < 85)
                send_frame($urandom_range(1, frame_q.size() - 1));
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            if (pick == 99)
                wait_results_drained();
        end
        no_idle = 1'b0;
    endtask

    // compare each uri transaction with the oldest expected one; checked mid-cycle
    // ahead of the rising edge that accepts it
    always @(negedge clk)
    begin
        ipd_uri_pkg::res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (uri_expect_q.size() == 0)
            begin
                $error("unexpected transaction: uri_byte %h uri_end %b uri_length %0d",
                       uri_byte, uri_end, uri_length);
                fail_cnt++;
            end
            else
            begin
                want = uri_expect_q.pop_front();
                if (uri_byte !== want.uri_byte)
                begin
                    $error("uri_byte expected %h actual %h", want.uri_byte, uri_byte);
                    fail_cnt++;
                end
                if (uri_end !== want.uri_end)
                begin
                    $error("uri_end expected %b actual %b", want.uri_end, uri_end);
                    fail_cnt++;
                end
                if (uri_length !== want.uri_length)
                begin
                    $error("uri_length expected %0d actual %0d", want.uri_length, uri_length);
                    fail_cnt++;
                end
                if (uri_truncated !== want.uri_truncated)
                begin
                    $error("uri_truncated expected %b actual %b",
                           want.uri_truncated, uri_truncated);
                    fail_cnt++;
                end
                if (want.uri_end)
                    ends_seen++;
                else
                    uri_seen++;
            end
        end
    end

    always @(posedge clk)
        out_ready <= no_idle || ($urandom_range(0, 99) >= 10);

    initial
    begin
        #3_000_000;
        $display("ipd_request_uri_parser_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        parse_ph   = ipd_uri_pkg::PH_IDLE;
        kept_cnt   = 0;
        tag_q      = '{default: 8'h00};
        trunc_flag = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_short_tag();
        test_notice_extremes();
        test_tag_cases();
        test_stray_plus();
        test_uri_overflow();
        test_random_stream(2000);

        wait_results_drained();
        repeat (16) @(posedge clk);
        if (uri_expect_q.size() != 0)
        begin
            $error("%0d expected transactions never arrived", uri_expect_q.size());
            fail_cnt++;
        end
        $display("fed %0d bytes incl. %0d random full notices, broken frames and line noise",
                 bytes_sent, notices_sent);
        $display("checked %0d uri bytes and %0d closing transactions, overflow included",
                 uri_seen, ends_seen);
        if (fail_cnt == 0)
            $display("ipd_request_uri_parser_unit_tb OK");
        else
            $display("ipd_request_uri_parser_unit_tb NOT OK");
        $finish;
    end

endmodule
